### rtl/core/lecm_pkg.sv
// ----------------------------------------------------------------------------
// lecm_pkg
// Shared types, effect codes and default periods for the LED effect
// color modulator.
// ----------------------------------------------------------------------------
package lecm_pkg;

    localparam logic [2:0] FX_SOLID   = 3'd0;
    localparam logic [2:0] FX_BREATHE = 3'd1;
    localparam logic [2:0] FX_PULSE   = 3'd2;
    localparam logic [2:0] FX_BLINK   = 3'd3;
    localparam logic [2:0] FX_FLASH   = 3'd4;
    localparam logic [2:0] FX_RAINBOW = 3'd5;

    localparam int REM_STAGES = 32;   // one elapsed bit per stage
    localparam int DIV_STAGES = 10;   // one quotient bit per stage

    // Pipeline item; later stages fill in the working fields.
    typedef struct packed {
        logic        vld;
        logic [2:0]  fx;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  idx;
        logic [31:0] el;
        logic [15:0] per;
        logic [15:0] rem;
        logic [25:0] num;
        logic [15:0] den;
        logic [9:0]  quo;
        logic        hz;
        logic        dark;
        logic [15:0] prod;
        logic [9:0]  pos;
        logic [7:0]  lvl;
    } t_item;

    function automatic logic [15:0] default_period(input logic [2:0] fx);
        logic [15:0] p;
        p = 16'd1;
        case (fx)
            FX_BREATHE: p = 16'd2000;
            FX_PULSE:   p = 16'd800;
            FX_BLINK:   p = 16'd600;
            FX_FLASH:   p = 16'd400;
            FX_RAINBOW: p = 16'd3000;
            default:    p = 16'd1;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/lecm_if.sv
// ----------------------------------------------------------------------------
// lecm_if
// Valid/ready channels for the pixel input and the modulated color output.
// ----------------------------------------------------------------------------
interface lecm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  effect;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [31:0] elapsed_ms;
    logic [15:0] period_ms;
    logic [7:0]  led_index;

    modport source (output valid, effect, red_in, green_in, blue_in, elapsed_ms,
                    period_ms, led_index, input ready);
    modport sink   (input valid, effect, red_in, green_in, blue_in, elapsed_ms,
                    period_ms, led_index, output ready);
endinterface

interface lecm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

### rtl/core/lecm_rem_pipe.sv
// ----------------------------------------------------------------------------
// lecm_rem_pipe
// Pipelined restoring remainder: rem = el % per, one dividend bit per stage.
// ----------------------------------------------------------------------------
module lecm_rem_pipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  lecm_pkg::t_item i_item,
    output lecm_pkg::t_item o_item
);

    lecm_pkg::t_item r_st [lecm_pkg::REM_STAGES];
    lecm_pkg::t_item n_st [lecm_pkg::REM_STAGES];

    genvar k;
    generate
        for (k = 0; k < lecm_pkg::REM_STAGES; k++) begin : g_stage
            lecm_pkg::t_item prev;
            logic [16:0]     trial;

            if (k == 0) begin : g_first
                always_comb begin
                    prev     = i_item;
                    prev.rem = '0;
                end
            end else begin : g_next
                assign prev = r_st[k-1];
            end

            always_comb begin
                n_st[k] = prev;
                trial   = {prev.rem, prev.el[lecm_pkg::REM_STAGES-1-k]};
                if (trial >= {1'b0, prev.per}) begin
                    n_st[k].rem = 16'(trial - {1'b0, prev.per});
                end else begin
                    n_st[k].rem = trial[15:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_st[k].vld <= 1'b0;
                end else if (i_en) begin
                    r_st[k] <= n_st[k];
                end
            end
        end
    endgenerate

    assign o_item = r_st[lecm_pkg::REM_STAGES-1];

endmodule

### rtl/core/led_effect_color_modulator_unit.sv
// ----------------------------------------------------------------------------
// led_effect_color_modulator_unit
// Per-pixel LED effect engine: solid, breathe, pulse, blink, flash, rainbow.
// ----------------------------------------------------------------------------
// Takes one pixel transaction per clock unless the output is stalled, and
// returns one color transaction per pixel, in order: 32 stages reduce elapsed_ms
// modulo the period one bit at a time, one stage sets up the wave, 10 stages
// produce the triangle/flash/hue quotient one bit at a time, one stage forms
// the brightness product and the output register applies the per-channel
// scaling. When the output is stalled the whole pipeline holds.
module led_effect_color_modulator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lecm_in_if.sink    i_in,
    lecm_out_if.source o_out
);

    logic            en;
    lecm_pkg::t_item n_in, rem_out, n_s1, r_s1, r_p1, n_p1, r_out, n_out;
    lecm_pkg::t_item r_dv [lecm_pkg::DIV_STAGES];
    lecm_pkg::t_item n_dv [lecm_pkg::DIV_STAGES];

    assign en         = !r_out.vld || o_out.ready;
    assign i_in.ready = en;

    // Entry: pick the period
    always_comb begin
        n_in     = '0;
        n_in.vld = i_in.valid;
        n_in.fx  = i_in.effect;
        n_in.r   = i_in.red_in;
        n_in.g   = i_in.green_in;
        n_in.b   = i_in.blue_in;
        n_in.idx = i_in.led_index;
        n_in.el  = i_in.elapsed_ms;
        n_in.per = (i_in.period_ms != 16'd0) ? i_in.period_ms
                                             : lecm_pkg::default_period(i_in.effect);
    end

    lecm_rem_pipe u_rem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_item (n_in),
        .o_item (rem_out)
    );

    // Setup: numerator/denominator for the quotient pipe
    logic [15:0] half, diff;
    always_comb begin
        n_s1      = rem_out;
        half      = {1'b0, rem_out.per[15:1]};
        diff      = (rem_out.rem < half) ? rem_out.rem : 16'(rem_out.per - rem_out.rem);
        n_s1.quo  = '0;
        n_s1.hz   = (half == 16'd0);
        n_s1.dark = 1'b0;
        n_s1.num  = ({10'd0, diff} << 8) - {10'd0, diff};
        n_s1.den  = half;
        case (rem_out.fx)
            lecm_pkg::FX_BLINK: begin
                n_s1.dark = (rem_out.rem >= half);
            end
            lecm_pkg::FX_FLASH: begin
                n_s1.dark = (|rem_out.el[31:16]) || (rem_out.el[15:0] >= rem_out.per);
                n_s1.num  = ({10'd0, rem_out.el[15:0]} << 8) - {10'd0, rem_out.el[15:0]};
                n_s1.den  = rem_out.per;
            end
            lecm_pkg::FX_RAINBOW: begin
                n_s1.num = ({10'd0, rem_out.rem} << 9) + ({10'd0, rem_out.rem} << 8);
                n_s1.den = rem_out.per;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (en) begin
            r_s1 <= n_s1;
        end
    end

    // Quotient pipe: one bit per stage, MSB first
    genvar j;
    generate
        for (j = 0; j < lecm_pkg::DIV_STAGES; j++) begin : g_div
            lecm_pkg::t_item prev;
            logic [25:0]     dsh;

            if (j == 0) begin : g_first
                assign prev = r_s1;
            end else begin : g_next
                assign prev = r_dv[j-1];
            end

            always_comb begin
                n_dv[j] = prev;
                dsh     = {10'd0, prev.den} << (lecm_pkg::DIV_STAGES - 1 - j);
                if (prev.num >= dsh) begin
                    n_dv[j].num = prev.num - dsh;
                    n_dv[j].quo[lecm_pkg::DIV_STAGES-1-j] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[j].vld <= 1'b0;
                end else if (en) begin
                    r_dv[j] <= n_dv[j];
                end
            end
        end
    endgenerate

    // Post 1: wave value, brightness product, hue position, level
    lecm_pkg::t_item dq;
    logic [7:0]  w, mop;
    logic [10:0] psum;
    always_comb begin
        dq   = r_dv[lecm_pkg::DIV_STAGES-1];
        n_p1 = dq;
        w    = (dq.hz || dq.quo > 10'd255) ? 8'd255 : dq.quo[7:0];
        mop  = (dq.fx == lecm_pkg::FX_PULSE) ? w : 8'd217;
        n_p1.prod = {8'd0, w} * {8'd0, mop};
        // 768 = 8 * 96, so the index offset folds to its low three bits
        psum = {1'b0, dq.quo} + (11'(dq.idx[2:0]) * 11'd96);
        n_p1.pos = (psum >= 11'd768) ? 10'(psum - 11'd768) : psum[9:0];
        n_p1.lvl = dq.r;
        if (dq.g > n_p1.lvl) n_p1.lvl = dq.g;
        if (dq.b > n_p1.lvl) n_p1.lvl = dq.b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.vld <= 1'b0;
        end else if (en) begin
            r_p1 <= n_p1;
        end
    end

    // Post 2: channel scaling into the output register
    logic [7:0]  cr, cg, cb, f, s;
    logic        scl;
    logic [15:0] mr, mg, mb;
    always_comb begin
        cr  = r_p1.r;
        cg  = r_p1.g;
        cb  = r_p1.b;
        f   = 8'd255;
        scl = 1'b0;
        s   = r_p1.pos[7:0];
        case (r_p1.fx)
            lecm_pkg::FX_BREATHE: begin
                f   = 8'd38 + r_p1.prod[15:8];
                scl = 1'b1;
            end
            lecm_pkg::FX_PULSE: begin
                f   = r_p1.prod[15:8];
                scl = 1'b1;
            end
            lecm_pkg::FX_BLINK: begin
                if (r_p1.dark) begin
                    cr = '0; cg = '0; cb = '0;
                end
            end
            lecm_pkg::FX_FLASH: begin
                f   = r_p1.dark ? 8'd0 : 8'd255 - r_p1.quo[7:0];
                scl = 1'b1;
            end
            lecm_pkg::FX_RAINBOW: begin
                f   = r_p1.lvl;
                scl = 1'b1;
                case (r_p1.pos[9:8])
                    2'd0:    begin cr = 8'd255 - s; cg = s; cb = '0; end
                    2'd1:    begin cr = '0; cg = 8'd255 - s; cb = s; end
                    default: begin cr = s; cg = '0; cb = 8'd255 - s; end
                endcase
            end
            default: ;
        endcase
        mr = {8'd0, cr} * {8'd0, f};
        mg = {8'd0, cg} * {8'd0, f};
        mb = {8'd0, cb} * {8'd0, f};
        n_out   = r_p1;
        n_out.r = scl ? mr[15:8] : cr;
        n_out.g = scl ? mg[15:8] : cg;
        n_out.b = scl ? mb[15:8] : cb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_out.vld;
    assign o_out.red_out   = r_out.r;
    assign o_out.green_out = r_out.g;
    assign o_out.blue_out  = r_out.b;

`ifndef SYNTHESIS
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
    a_flash_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1.vld && r_p1.fx == lecm_pkg::FX_FLASH && !r_p1.dark |-> r_p1.quo <= 10'd255)
        else $error("flash quotient out of range");
    a_hue_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1.vld && r_p1.fx == lecm_pkg::FX_RAINBOW |-> r_p1.pos < 10'd768)
        else $error("hue position out of range");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_p1))
        else $error("pipeline moved during stall");
`endif

endmodule

### sim/lecm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lecm_checker
// Watches the pixel and color channels, predicts each modulated color and
// compares it, in order, with what the unit returns.
// ----------------------------------------------------------------------------
module lecm_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lecm_in_if.sink    i_in,
    lecm_out_if.sink   i_out,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_color;

    t_color color_q[$];

    function automatic logic [7:0] scale8(input logic [31:0] c, input logic [31:0] f);
        logic [15:0] m;
        m = c[7:0] * f[7:0];
        return m[15:8];
    endfunction

    function automatic logic [31:0] triangle(input logic [31:0] el, input logic [31:0] p);
        logic [31:0] ph;
        logic [31:0] h;
        logic [31:0] v;
        ph = el % p;
        h = p / 2;
        if (h == 0) return 255;
        if (ph < h) v = ph * 255 / h;
        else v = (p - ph) * 255 / h;
        return (v > 255) ? 255 : v;
    endfunction

    function automatic t_color modulate(input logic [2:0] fx, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input logic [31:0] el, input logic [15:0] per,
                                        input logic [7:0] idx);
        t_color c;
        logic [31:0] p;
        logic [31:0] w;
        logic [31:0] f;
        logic [31:0] pos;
        logic [31:0] s;
        logic [7:0] hr;
        logic [7:0] hg;
        logic [7:0] hb;
        logic [7:0] lvl;
        logic [63:0] wide;
        c = '{r, g, b};
        case (fx)
            lecm_pkg::FX_BREATHE: begin
                p = per ? per : 2000;
                w = triangle(el, p);
                f = 38 + ((w * 217) >> 8);
                c = '{scale8(r, f), scale8(g, f), scale8(b, f)};
            end
            lecm_pkg::FX_PULSE: begin
                p = per ? per : 800;
                w = triangle(el, p);
                f = (w * w) >> 8;
                c = '{scale8(r, f), scale8(g, f), scale8(b, f)};
            end
            lecm_pkg::FX_BLINK: begin
                p = per ? per : 600;
                if ((el % p) >= p / 2) c = '0;
            end
            lecm_pkg::FX_FLASH: begin
                p = per ? per : 400;
                if (el >= p) c = '0;
                else begin
                    // 32-bit wrap of el*255 matters only when el >= p, never here
                    wide = el * 64'd255;
                    f = 255 - wide[31:0] / p;
                    c = '{scale8(r, f), scale8(g, f), scale8(b, f)};
                end
            end
            lecm_pkg::FX_RAINBOW: begin
                p = per ? per : 3000;
                pos = ((el % p) * 768 / p + idx * 96) % 768;
                s = pos % 256;
                case (pos / 256)
                    0: begin
                        hr = 8'(255 - s); hg = 8'(s);       hb = '0;
                    end
                    1: begin
                        hr = '0;          hg = 8'(255 - s); hb = 8'(s);
                    end
                    default: begin
                        hr = 8'(s);       hg = '0;          hb = 8'(255 - s);
                    end
                endcase
                lvl = r;
                if (g > lvl) lvl = g;
                if (b > lvl) lvl = b;
                c = '{scale8(hr, lvl), scale8(hg, lvl), scale8(hb, lvl)};
            end
            default: ;
        endcase
        return c;
    endfunction

    assign o_pending = color_q.size();

    always @(posedge i_clk) begin
        t_color exp_c;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                color_q.push_back(modulate(i_in.effect, i_in.red_in, i_in.green_in,
                    i_in.blue_in, i_in.elapsed_ms, i_in.period_ms, i_in.led_index));
            if (i_out.valid && i_out.ready) begin
                if (color_q.size() == 0) begin
                    $display("%0t: unexpected color transaction %h %h %h", $time,
                             i_out.red_out, i_out.green_out, i_out.blue_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_c = color_q.pop_front();
                    if (exp_c != {i_out.red_out, i_out.green_out, i_out.blue_out}) begin
                        $display("%0t: expected rgb %h %h %h, actual %h %h %h", $time,
                                 exp_c.r, exp_c.g, exp_c.b,
                                 i_out.red_out, i_out.green_out, i_out.blue_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random pixel transactions with random gaps and output
// stalls; the checker predicts and compares every color.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_RANDOM = 1500;
    localparam int LATENCY  = 45;
    localparam int LIMIT    = 400000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    bit   hold_off;
    bit   stim_done;

    lecm_in_if  pix_if ();
    lecm_out_if col_if ();

    led_effect_color_modulator_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pix_if.sink),
        .o_out  (col_if.source)
    );

    lecm_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (pix_if.sink),
        .i_out       (col_if.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic send_pixel(input logic [2:0] fx, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [31:0] el,
                              input logic [15:0] per, input logic [7:0] idx, input bit idle);
        int n;
        n = idle ? gap_len() : 0;
        if (n > 0) begin
            pix_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.effect     <= fx;
        pix_if.red_in     <= r;
        pix_if.green_in   <= g;
        pix_if.blue_in    <= b;
        pix_if.elapsed_ms <= el;
        pix_if.period_ms  <= per;
        pix_if.led_index  <= idx;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_period();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 3));
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 3000));
        endcase
    endfunction

    function automatic logic [31:0] rand_elapsed(input logic [15:0] per);
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 8000);
            default: return $urandom_range(0, (per == 0 ? 3000 : per) * 2);
        endcase
    endfunction

    // output stalls: random, with one long hold-off while input keeps coming
    initial begin
        col_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                col_if.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (stim_done && pending == 0) begin
                col_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                col_if.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
                repeat (($urandom_range(0, 9) == 0) ? gap_len() + 1 : 1) @(posedge i_clk);
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] per;
        hold_off  = 1'b0;
        stim_done = 1'b0;
        i_rst_n           <= 1'b0;
        pix_if.valid      <= 1'b0;
        pix_if.effect     <= lecm_pkg::FX_SOLID;
        pix_if.red_in     <= '0;
        pix_if.green_in   <= '0;
        pix_if.blue_in    <= '0;
        pix_if.elapsed_ms <= '0;
        pix_if.period_ms  <= '0;
        pix_if.led_index  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every effect, field extremes, unused codes, period of one,
        // odd period at mid-phase, flash edge
        send_pixel(lecm_pkg::FX_SOLID, 8'hff, 8'h00, 8'h80, 32'hffffffff, 16'hffff, 8'hff,
                   1'b0);
        send_pixel(3'd6, 8'h12, 8'h34, 8'h56, 32'd5, 16'd0, 8'd0, 1'b0);
        send_pixel(3'd7, 8'hff, 8'hff, 8'hff, 32'd0, 16'd7, 8'd1, 1'b0);
        send_pixel(lecm_pkg::FX_BREATHE, 8'hff, 8'hff, 8'hff, 32'd1000, 16'd0, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_BREATHE, 8'hff, 8'h80, 8'h01, 32'd0, 16'd0, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_BREATHE, 8'hff, 8'hff, 8'hff, 32'd12345, 16'd1, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_PULSE, 8'hff, 8'hff, 8'hff, 32'd400, 16'd0, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_PULSE, 8'hff, 8'hff, 8'hff, 32'd3, 16'd7, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_PULSE, 8'hff, 8'hff, 8'hff, 32'd4, 16'd7, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_BREATHE, 8'hff, 8'h00, 8'hff, 32'd1, 16'd3, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_BLINK, 8'hff, 8'hff, 8'hff, 32'd299, 16'd0, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_BLINK, 8'hff, 8'hff, 8'hff, 32'd300, 16'd0, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_BLINK, 8'hff, 8'hff, 8'hff, 32'd9, 16'd1, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_FLASH, 8'hff, 8'hff, 8'hff, 32'd0, 16'd0, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_FLASH, 8'hff, 8'hff, 8'hff, 32'd399, 16'd0, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_FLASH, 8'hff, 8'hff, 8'hff, 32'd400, 16'd0, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_FLASH, 8'hff, 8'hff, 8'hff, 32'd65534, 16'hffff, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_RAINBOW, 8'hff, 8'h00, 8'h00, 32'd0, 16'd0, 8'd0, 1'b0);
        send_pixel(lecm_pkg::FX_RAINBOW, 8'h00, 8'hff, 8'h00, 32'd1500, 16'd0, 8'd1, 1'b0);
        send_pixel(lecm_pkg::FX_RAINBOW, 8'h00, 8'h00, 8'hff, 32'd2999, 16'd0, 8'd255, 1'b0);
        send_pixel(lecm_pkg::FX_RAINBOW, 8'h80, 8'h40, 8'hff, 32'hffffffff, 16'hffff, 8'd7,
                   1'b0);
        send_pixel(lecm_pkg::FX_RAINBOW, 8'hff, 8'hff, 8'hff, 32'd5, 16'd1, 8'd3, 1'b0);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 300) hold_off = 1'b1;
            per = rand_period();
            send_pixel(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       rand_elapsed(per), per, 8'($urandom_range(0, 255)),
                       ($urandom_range(0, 3) == 0));
        end
        pix_if.valid <= 1'b0;
        stim_done = 1'b1;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### files.f
rtl/core/lecm_pkg.sv
rtl/core/lecm_if.sv
rtl/core/lecm_rem_pipe.sv
rtl/core/led_effect_color_modulator_unit.sv
sim/lecm_checker.sv
sim/tb_top.sv
